// ===== hdl/bah_pkg.sv =====
// ============================================================================
// bah_pkg
// Shared types and constants of the block average hold downsampler: sample
// format, configuration register map and controller states.
// ============================================================================
package bah_pkg;

    // Sample and gain formats
    localparam int SAMPLE_BITS   = 24;
    localparam int GAIN_BITS     = 16;
    localparam int GAIN_FRAC     = 12;
    localparam int LEN_BITS      = 7;

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_LENGTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ADD_MODE     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIX_GAIN     = 2'd2;

    // Register reset values
    localparam logic [LEN_BITS-1:0]         LEN_RESET  = 7'd1;
    localparam logic signed [GAIN_BITS-1:0] GAIN_RESET = 16'sd4096;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_SCALE,
        ST_READ,
        ST_LOAD,
        ST_OUT
    } t_state;

endpackage

// ===== hdl/bah_in_if.sv =====
// ============================================================================
// bah_in_if
// Input channel: one audio sample, its mix value and the end-of-run mark.
// ============================================================================
interface bah_in_if;

    logic                                  valid;
    logic                                  ready;
    logic signed [bah_pkg::SAMPLE_BITS-1:0] sample;
    logic signed [bah_pkg::SAMPLE_BITS-1:0] mix_in;
    logic                                  end_of_run;

    modport source (output valid, output sample, output mix_in, output end_of_run,
                    input ready);
    modport sink   (input valid, input sample, input mix_in, input end_of_run,
                    output ready);

endinterface

// ===== hdl/bah_out_if.sv =====
// ============================================================================
// bah_out_if
// Output channel: one held output sample and the last-of-block flag.
// ============================================================================
interface bah_out_if;

    logic                                  valid;
    logic                                  ready;
    logic signed [bah_pkg::SAMPLE_BITS-1:0] out_sample;
    logic                                  last_of_block;

    modport source (output valid, output out_sample, output last_of_block,
                    input ready);
    modport sink   (input valid, input out_sample, input last_of_block,
                    output ready);

endinterface

// ===== hdl/bah_mix_ram.sv =====
// ============================================================================
// bah_mix_ram
// Mix value store: one write port, one read port, registered read data.
// ============================================================================
module bah_mix_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 24
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bah_divider.sv =====
// ============================================================================
// bah_divider
// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ============================================================================
module bah_divider #(
    parameter int SUM_W = 30,
    parameter int DIV_W = 7,
    parameter int Q_W   = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic signed [Q_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [SUM_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;

    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   rem_diff;
    logic             q_bit;
    logic [Q_W-1:0]   quo_mag;

    // One restoring step
    always_comb begin
        rem_sh   = {r_rem, r_quo[SUM_W-1]};
        rem_diff = rem_sh - {1'b0, r_div};
        q_bit    = (rem_sh >= {1'b0, r_div});
    end

    // Control: busy flag, step count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: load magnitude, then shift in quotient bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_quo <= i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], q_bit};
            r_rem <= q_bit ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        end
    end

    // Restore the sign
    assign quo_mag = r_quo[Q_W-1:0];
    assign o_quot  = r_neg ? -$signed(quo_mag) : $signed(quo_mag);
    assign o_done  = r_done;

endmodule

// ===== hdl/block_average_hold_downsampler.sv =====
// ============================================================================
// block_average_hold_downsampler
// Boxcar block average held for the block length (add mode: mix + gain * avg).
// ============================================================================
// Usage:
//   i_in carries sample, mix_in and end_of_run; a transaction completes when
//   valid and ready are both high. A block closes when it holds block_length
//   samples (0 acts as 1, values above MAX_BLOCK act as MAX_BLOCK) or when
//   end_of_run is set. Each input of an open block gives no output.
//   On closing, a restoring divider forms the average, states ST_MUL and
//   ST_SCALE form the gained average, and then each of the N copies is
//   taken out of the mix store through ST_READ, ST_LOAD and ST_OUT (read,
//   add and saturate, present). i_in is not ready from the closing input
//   until the last copy has left. o_out holds its transaction while ready
//   is low.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data;
//   the user must write it only while the block is idle, which the block
//   itself does not enforce.
//   Reset empties the open block and restores block_length 1, add_mode 0 and
//   mix_gain 1.0; the mix store needs no clearing.
// ============================================================================
module block_average_hold_downsampler #(
    parameter int MAX_BLOCK = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bah_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [bah_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    bah_in_if.sink                              i_in,
    bah_out_if.source                           o_out
);

    localparam int SW     = bah_pkg::SAMPLE_BITS;
    localparam int FILL_W = $clog2(MAX_BLOCK + 1);
    localparam int ADDR_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int SUM_W  = SW + $clog2(MAX_BLOCK) + 1;
    localparam int CMP_W  = (FILL_W > bah_pkg::LEN_BITS) ? FILL_W : bah_pkg::LEN_BITS;
    localparam int P_W    = SW + bah_pkg::GAIN_BITS;
    localparam int G_W    = P_W - bah_pkg::GAIN_FRAC;
    localparam int A_W    = G_W + 1;

    // Configuration registers
    logic [bah_pkg::LEN_BITS-1:0]         r_block_length;
    logic                                 r_add_mode;
    logic signed [bah_pkg::GAIN_BITS-1:0] r_mix_gain;

    // Block state
    bah_pkg::t_state     r_state;
    bah_pkg::t_state     n_state;
    logic signed [SUM_W-1:0] r_sum;
    logic [FILL_W-1:0]   r_fill;
    logic [FILL_W-1:0]   r_cnt;
    logic [FILL_W-1:0]   r_k;
    logic signed [SW-1:0]  r_avg;
    logic signed [P_W-1:0] r_prod;
    logic signed [G_W-1:0] r_gadd;
    logic signed [SW-1:0]  r_out_sample;
    logic                  r_out_last;

    // Combinational signals
    logic                    in_ready;
    logic                    in_acc;
    logic signed [SUM_W-1:0] sum_next;
    logic [FILL_W-1:0]       fill_next;
    logic [CMP_W-1:0]        len_ext;
    logic [CMP_W-1:0]        len_eff;
    logic                    close_blk;
    logic                    div_done;
    logic signed [SW-1:0]    div_quot;
    logic [SW-1:0]           mix_q;
    logic signed [P_W-1:0]   prod_bias;
    logic signed [A_W-1:0]   mix_sum;
    logic signed [SW-1:0]    mix_sat;
    logic                    k_last;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= bah_pkg::LEN_RESET;
            r_add_mode     <= 1'b0;
            r_mix_gain     <= bah_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bah_pkg::CFG_BLOCK_LENGTH: r_block_length <= i_cfg_data[bah_pkg::LEN_BITS-1:0];
                bah_pkg::CFG_ADD_MODE:     r_add_mode     <= i_cfg_data[0];
                bah_pkg::CFG_MIX_GAIN:     r_mix_gain     <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Accumulate and decide whether the block closes
    always_comb begin
        in_acc    = i_in.valid && in_ready;
        sum_next  = r_sum + SUM_W'(i_in.sample);
        fill_next = r_fill + FILL_W'(1);
        len_ext   = CMP_W'(r_block_length);
        if (len_ext == '0) begin
            len_eff = CMP_W'(1);
        end else if (len_ext > CMP_W'(MAX_BLOCK)) begin
            len_eff = CMP_W'(MAX_BLOCK);
        end else begin
            len_eff = len_ext;
        end
        close_blk = i_in.end_of_run || (CMP_W'(fill_next) >= len_eff);
        k_last    = (r_k + FILL_W'(1) == r_cnt);
    end

    // Mix value store
    bah_mix_ram #(
        .DEPTH  (MAX_BLOCK),
        .ADDR_W (ADDR_W),
        .DATA_W (SW)
    ) u_mix_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (i_in.mix_in),
        .i_raddr (r_k[ADDR_W-1:0]),
        .o_rdata (mix_q)
    );

    // Block average divider
    bah_divider #(
        .SUM_W (SUM_W),
        .DIV_W (FILL_W),
        .Q_W   (SW)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc && close_blk),
        .i_dividend (sum_next),
        .i_divisor  (fill_next),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Scale the gain product toward zero, add the mix value, saturate
    always_comb begin
        prod_bias = r_prod + (r_prod[P_W-1] ? P_W'((1 << bah_pkg::GAIN_FRAC) - 1) : P_W'(0));
        mix_sum   = A_W'($signed(mix_q)) + A_W'(r_gadd);
        if (mix_sum[A_W-1:SW-1] == '0 || mix_sum[A_W-1:SW-1] == '1) begin
            mix_sat = mix_sum[SW-1:0];
        end else if (mix_sum[A_W-1]) begin
            mix_sat = {1'b1, {(SW-1){1'b0}}};
        end else begin
            mix_sat = {1'b0, {(SW-1){1'b1}}};
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bah_pkg::ST_IDLE:  if (in_acc && close_blk) n_state = bah_pkg::ST_DIV;
            bah_pkg::ST_DIV:   if (div_done) n_state = bah_pkg::ST_MUL;
            bah_pkg::ST_MUL:   n_state = bah_pkg::ST_SCALE;
            bah_pkg::ST_SCALE: n_state = bah_pkg::ST_READ;
            bah_pkg::ST_READ:  n_state = bah_pkg::ST_LOAD;
            bah_pkg::ST_LOAD:  n_state = bah_pkg::ST_OUT;
            bah_pkg::ST_OUT: begin
                if (o_out.ready) begin
                    n_state = r_out_last ? bah_pkg::ST_IDLE : bah_pkg::ST_READ;
                end
            end
            default:           n_state = bah_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        in_ready    = (r_state == bah_pkg::ST_IDLE);
        o_out.valid = (r_state == bah_pkg::ST_OUT);
    end

    assign i_in.ready          = in_ready;
    assign o_out.out_sample    = r_out_sample;
    assign o_out.last_of_block = r_out_last;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bah_pkg::ST_IDLE;
            r_sum   <= '0;
            r_fill  <= '0;
            r_cnt   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                if (close_blk) begin
                    r_sum <= '0;
                    r_fill <= '0;
                    r_cnt <= fill_next;
                    r_k   <= '0;
                end else begin
                    r_sum  <= sum_next;
                    r_fill <= fill_next;
                end
            end
            if (r_state == bah_pkg::ST_OUT && o_out.ready) begin
                r_k <= r_k + FILL_W'(1);
            end
        end
    end

    // Datapath registers: average, gain product, output transaction
    always_ff @(posedge i_clk) begin
        if (r_state == bah_pkg::ST_DIV && div_done) begin
            r_avg <= div_quot;
        end
        if (r_state == bah_pkg::ST_MUL) begin
            r_prod <= P_W'(r_avg) * P_W'(r_mix_gain);
        end
        if (r_state == bah_pkg::ST_SCALE) begin
            r_gadd <= prod_bias[P_W-1:bah_pkg::GAIN_FRAC];
        end
        if (r_state == bah_pkg::ST_LOAD) begin
            r_out_sample <= r_add_mode ? mix_sat : r_avg;
            r_out_last   <= k_last;
        end
    end

endmodule

// ===== tb/sv/block_average_hold_downsampler_test.sv =====
// ----------------------------------------------------------------------------
// block_average_hold_downsampler_test
// Self-checking bench for the block average hold downsampler. A directed table
// covers reset behavior, sample extremes, saturation in add mode, rounding
// toward zero, early block close and the odd block lengths. Random phases with
// fresh register settings follow. Every output transaction is compared against
// an in-bench model of the averaging and hold logic, or the row's known value.
// ----------------------------------------------------------------------------
module block_average_hold_downsampler_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint LEVEL_MAX = (longint'(1) <<< (bah_pkg::SAMPLE_BITS - 1)) - 1;
    localparam longint LEVEL_MIN = -LEVEL_MAX - 1;
    localparam int     MAX_LEN   = 64;
    localparam longint GAIN_ONE  = longint'(1) <<< bah_pkg::GAIN_FRAC;

    typedef logic signed [bah_pkg::SAMPLE_BITS-1:0] t_level;

    typedef struct packed {
        t_level level;
        logic   last;
    } t_held;

    typedef enum logic {ROW_SAMPLE, ROW_CONFIG} t_row_kind;

    typedef struct packed {
        t_row_kind                         kind;
        logic [bah_pkg::CFG_IDX_BITS-1:0]  reg_idx;
        logic [bah_pkg::CFG_DATA_BITS-1:0] reg_val;
        t_level                            sample;
        t_level                            mix;
        logic                              eor;
        logic                              typed;
        t_level                            want;
    } t_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [bah_pkg::CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [bah_pkg::CFG_DATA_BITS-1:0] i_cfg_data;

    bah_in_if  in_ch ();
    bah_out_if out_ch ();

    block_average_hold_downsampler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Shadow registers and open-block state of the averaging model
    logic [bah_pkg::LEN_BITS-1:0]         len_cfg;
    logic                                 add_cfg;
    logic signed [bah_pkg::GAIN_BITS-1:0] gain_cfg;
    longint                               acc_sum;
    int                                   acc_fill;
    t_level                               mix_mem [0:MAX_LEN-1];

    t_held held_q [$];
    t_row  plan [$];
    int    mismatches = 0;
    bit    calm = 1'b0;
    int    sink_hold = 0;
    int    sink_draw;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int pause_draw();
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic t_level clip_level(longint x);
        if (x > LEVEL_MAX) return t_level'(LEVEL_MAX);
        if (x < LEVEL_MIN) return t_level'(LEVEL_MIN);
        return t_level'(x);
    endfunction

    function automatic t_level pick_level();
        case ($urandom_range(0, 7))
            0: return t_level'(LEVEL_MAX);
            1: return t_level'(LEVEL_MIN);
            2: return t_level'(int'($urandom_range(0, 16)) - 8);
            default: return t_level'($urandom);
        endcase
    endfunction

    function automatic logic [bah_pkg::CFG_DATA_BITS-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return bah_pkg::GAIN_RESET;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_row cfg_row(logic [bah_pkg::CFG_IDX_BITS-1:0] idx,
                                     logic [bah_pkg::CFG_DATA_BITS-1:0] val);
        t_row r;
        r = '0;
        r.kind    = ROW_CONFIG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_row sample_row(t_level s, t_level m, logic eor);
        t_row r;
        r = '0;
        r.kind   = ROW_SAMPLE;
        r.sample = s;
        r.mix    = m;
        r.eor    = eor;
        return r;
    endfunction

    // Row whose single result is known by inspection
    function automatic t_row held_row(t_level s, t_level m, logic eor, t_level want);
        t_row r;
        r = sample_row(s, m, eor);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    // Accumulate one sample; on block close, queue one held value per position
    task automatic avg_predict(input t_level s, input t_level m, input logic eor);
        longint eff;
        longint avg;
        longint g;
        t_held  h;
        if (len_cfg == 0)
            eff = 1;
        else if (len_cfg > MAX_LEN)
            eff = MAX_LEN;
        else
            eff = len_cfg;
        if (acc_fill < MAX_LEN)
            mix_mem[acc_fill] = m;
        acc_sum += s;
        acc_fill++;
        if (eor || acc_fill >= eff) begin
            avg = acc_sum / acc_fill;
            for (int k = 0; k < acc_fill; k++) begin
                if (add_cfg) begin
                    g = (avg * gain_cfg) / GAIN_ONE;
                    h.level = clip_level(longint'(mix_mem[k]) + g);
                end else begin
                    h.level = t_level'(avg);
                end
                h.last = (k == acc_fill - 1);
                held_q.push_back(h);
            end
            acc_sum  = 0;
            acc_fill = 0;
        end
    endtask

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Offer one sample after a random gap and wait for the transaction
    task automatic send_sample(input t_level s, input t_level m, input logic eor);
        int gap;
        gap = pause_draw();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.sample     <= s;
        in_ch.mix_in     <= m;
        in_ch.end_of_run <= eor;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        avg_predict(s, m, eor);
    endtask

    // Hold off input until every queued result has drained, then let the block settle
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (held_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [bah_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [bah_pkg::CFG_DATA_BITS-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            bah_pkg::CFG_BLOCK_LENGTH: len_cfg  = val[bah_pkg::LEN_BITS-1:0];
            bah_pkg::CFG_ADD_MODE:     add_cfg  = val[0];
            bah_pkg::CFG_MIX_GAIN:     gain_cfg = val;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sink side: check each output transaction, then draw the next stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b1;
            sink_hold    <= 0;
        end else if (out_ch.valid && out_ch.ready) begin
            if (held_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected output %0d last=%b",
                                        out_ch.out_sample, out_ch.last_of_block));
            end else begin
                if (out_ch.out_sample !== held_q[0].level)
                    flag_mismatch($sformatf("out_sample got %0d want %0d",
                                            out_ch.out_sample, held_q[0].level));
                if (out_ch.last_of_block !== held_q[0].last)
                    flag_mismatch($sformatf("last_of_block got %b want %b",
                                            out_ch.last_of_block, held_q[0].last));
                void'(held_q.pop_front());
            end
            sink_draw = pause_draw();
            out_ch.ready <= (sink_draw == 0);
            sink_hold    <= sink_draw;
        end else if (sink_hold != 0) begin
            sink_hold    <= sink_hold - 1;
            out_ch.ready <= (sink_hold == 1);
        end
    end

    initial begin
        int     phase_len;
        int     phase_items;
        t_level s;

        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        in_ch.valid      = 1'b0;
        in_ch.sample     = '0;
        in_ch.mix_in     = '0;
        in_ch.end_of_run = 1'b0;

        len_cfg  = bah_pkg::LEN_RESET;
        add_cfg  = 1'b0;
        gain_cfg = bah_pkg::GAIN_RESET;
        acc_sum  = 0;
        acc_fill = 0;
        foreach (mix_mem[i]) mix_mem[i] = '0;

        // Directed table: defaults after reset, extremes, add-mode saturation,
        // rounding, early close, zero length and length lowered mid-block
        plan.push_back(held_row(5, 0, 1'b0, 5));
        plan.push_back(held_row(t_level'(LEVEL_MAX), t_level'(LEVEL_MIN), 1'b0,
                                t_level'(LEVEL_MAX)));
        plan.push_back(held_row(t_level'(LEVEL_MIN), t_level'(LEVEL_MAX), 1'b0,
                                t_level'(LEVEL_MIN)));
        plan.push_back(held_row(-1, 0, 1'b0, -1));
        plan.push_back(held_row(77, 3, 1'b1, 77));
        plan.push_back(cfg_row(bah_pkg::CFG_ADD_MODE, 16'd1));
        plan.push_back(held_row(100, t_level'(LEVEL_MAX), 1'b0, t_level'(LEVEL_MAX)));
        plan.push_back(held_row(-100, t_level'(LEVEL_MIN), 1'b0, t_level'(LEVEL_MIN)));
        plan.push_back(cfg_row(bah_pkg::CFG_MIX_GAIN, 16'h8000));
        plan.push_back(held_row(t_level'(LEVEL_MAX), 0, 1'b0, t_level'(LEVEL_MIN)));
        plan.push_back(cfg_row(bah_pkg::CFG_MIX_GAIN, 16'h7FFF));
        plan.push_back(held_row(t_level'(LEVEL_MAX), 0, 1'b0, t_level'(LEVEL_MAX)));
        plan.push_back(cfg_row(bah_pkg::CFG_MIX_GAIN, 16'h0000));
        plan.push_back(held_row(123, -77, 1'b0, -77));
        plan.push_back(cfg_row(bah_pkg::CFG_MIX_GAIN, 16'h0001));
        plan.push_back(held_row(-4095, 10, 1'b0, 10));
        plan.push_back(cfg_row(bah_pkg::CFG_ADD_MODE, 16'd0));
        plan.push_back(cfg_row(bah_pkg::CFG_BLOCK_LENGTH, 16'd3));
        plan.push_back(sample_row(1, 0, 1'b0));
        plan.push_back(sample_row(2, 0, 1'b0));
        plan.push_back(sample_row(4, 0, 1'b0));
        plan.push_back(sample_row(-1, 0, 1'b0));
        plan.push_back(sample_row(-2, 0, 1'b0));
        plan.push_back(sample_row(-4, 0, 1'b0));
        plan.push_back(sample_row(10, 0, 1'b0));
        plan.push_back(sample_row(11, 0, 1'b1));
        plan.push_back(cfg_row(bah_pkg::CFG_BLOCK_LENGTH, 16'd0));
        plan.push_back(held_row(42, 0, 1'b0, 42));
        plan.push_back(cfg_row(bah_pkg::CFG_BLOCK_LENGTH, 16'd5));
        plan.push_back(sample_row(1, 0, 1'b0));
        plan.push_back(sample_row(2, 0, 1'b0));
        plan.push_back(sample_row(3, 0, 1'b0));
        plan.push_back(cfg_row(bah_pkg::CFG_BLOCK_LENGTH, 16'd2));
        plan.push_back(sample_row(4, 0, 1'b0));

        // Reset once, synchronous
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int i = 0; i < plan.size(); i++) begin
            if (plan[i].kind == ROW_CONFIG) begin
                settle();
                cfg_write(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_sample(plan[i].sample, plan[i].mix, plan[i].eor);
                if (plan[i].typed) begin
                    void'(held_q.pop_back());
                    held_q.push_back({plan[i].want, 1'b1});
                end
            end
        end

        // Random phases, each with fresh register settings
        for (int p = 0; p < 13; p++) begin
            case (p)
                0: phase_len = 127;
                1: phase_len = 0;
                2: phase_len = 65;
                3: phase_len = MAX_LEN;
                default: phase_len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20)
                                                                 : $urandom_range(1, 8);
            endcase
            phase_items = (p == 0) ? MAX_LEN : (p == 3) ? 20 : 7;
            calm = ($urandom_range(0, 3) == 0);

            // Stall the input until the previous phase has drained
            settle();
            cfg_write(bah_pkg::CFG_BLOCK_LENGTH, bah_pkg::CFG_DATA_BITS'(phase_len));
            cfg_write(bah_pkg::CFG_ADD_MODE, bah_pkg::CFG_DATA_BITS'($urandom_range(0, 1)));
            cfg_write(bah_pkg::CFG_MIX_GAIN, pick_gain());

            for (int n = 0; n < phase_items; n++) begin
                s = pick_level();
                // Keep the oversized-length phase free of early closes
                if (p == 0)
                    send_sample(s, pick_level(), 1'b0);
                else if (p == 3 || p == 12)
                    send_sample(s, pick_level(), n == phase_items - 1);
                else
                    send_sample(s, pick_level(), $urandom_range(0, 5) == 0);
            end
        end

        settle();
        repeat (64) @(posedge i_clk);

        if (mismatches == 0 && held_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
